>>> rtl/software_timer_bank_macros.svh
// Assertion macros for the timer bank checker.
// Used by software_timer_bank_chk only.
`ifndef SOFTWARE_TIMER_BANK_MACROS_SVH
`define SOFTWARE_TIMER_BANK_MACROS_SVH
`define STB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same check, also active while reset is asserted
`define STB_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/stb_pkg.sv
// Shared types and constants for the timer bank.
// No dependencies.
package stb_pkg;
  localparam int unsigned NumSlots = 16;
  localparam int unsigned TickRate = 100;
  localparam int unsigned SlotW = $clog2(NumSlots);

  typedef enum logic [1:0] {
    ActInstall = 2'd0,
    ActRemove  = 2'd1,
    ActTick    = 2'd2,
    ActNone    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KindAck    = 2'd0,
    KindExpire = 2'd1,
    KindIdle   = 2'd2,
    KindRsvd   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  slot;
    logic [15:0] timeout;
    logic [15:0] resolution;
    logic        periodic;
    logic [7:0]  timer_priority;
    logic        task_running;
    logic [7:0]  running_priority;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  expired_slot;
    logic        deliver;
    logic        last;
    logic [31:0] tick_count;
    logic [31:0] uptime_seconds;
  } out_t;

  typedef struct packed {
    logic        periodic;
    logic [7:0]  prio;
    logic [31:0] reload;
    logic [31:0] remaining;
  } slot_t;
endpackage

>>> rtl/stb_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on stb_pkg.
module stb_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [22:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [22:0] quo_o
);
  import stb_pkg::*;
  logic [22:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] trial;

  always_comb begin
    trial  = {rem_q[15:0], quo_q[22]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = 5'd23;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_i}) begin
        rem_d = trial - {1'b0, den_i};
        quo_d = {quo_q[21:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[21:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quo_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end
endmodule

>>> rtl/stb_ram.sv
// Slot table memory, one write and one registered read port.
// Depends on stb_pkg.
module stb_ram (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [stb_pkg::SlotW-1:0] waddr_i,
  input  stb_pkg::slot_t         wdata_i,
  input  logic [stb_pkg::SlotW-1:0] raddr_i,
  output stb_pkg::slot_t         rdata_o
);
  import stb_pkg::*;
  slot_t mem [NumSlots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/software_timer_bank.sv
// Timer bank top level: sequencer over the slot memory and divider.
// Install: the slot is written and acknowledged once the 23-step divider is done.
// Tick: each slot is read (StRead) then updated (StUpd), with an emit state per expiry
// (separate read and write ports of the slot RAM); output stalls hold the sequencer.
// One item in flight; the output register holds a waiting beat while the next item enters.
// Reset clears valid bits, counters and control; slot memory is not cleared.
module software_timer_bank (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  stb_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output stb_pkg::out_t   out_data_o
);
  import stb_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDiv, StRead, StUpd, StEmit, StFinal
  } state_e;

  state_e         state_q;
  in_t            item_q;
  logic [NumSlots-1:0] valid_q;
  logic [SlotW-1:0] idx_q;
  logic           any_q;
  logic [31:0]    ticks_q, secs_q;
  logic [$clog2(TickRate+1)-1:0] sub_q;
  logic           ovld_q, ovld_d;
  out_t           obuf_q, obuf_d;
  logic [7:0]     rdata_prio_q;
  logic           more_q;
  logic [NumSlots-1:0] hi_mask;
  logic [NumSlots-1:0] shadow_le1_q;

  logic           div_start, div_done;
  logic [22:0]    div_quo;
  logic           we;
  logic [SlotW-1:0] waddr, raddr;
  slot_t          wdata, rdata;
  logic           out_free, acc, exp_hit, last_idx;
  logic           fin_silent, emit_exp, emit_fin;

  assign out_free   = !ovld_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);
  assign acc        = in_valid_i && !in_stall_o;
  assign out_valid_o = ovld_q;
  assign out_data_o  = obuf_q;
  assign last_idx   = (idx_q == SlotW'(NumSlots - 1));
  assign exp_hit    = valid_q[idx_q] && (rdata.remaining <= 32'd1);
  assign fin_silent = (item_q.action == ActTick) && any_q;
  assign emit_exp   = (state_q == StEmit) && out_free;
  assign emit_fin   = (state_q == StFinal) && out_free && !fin_silent;

  stb_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i  (23'(in_data_i.timeout) * 23'(TickRate)),
    .den_i  ((item_q.resolution == 16'd0) ? 16'd1 : item_q.resolution),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  stb_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign div_start = acc && (in_data_i.action == ActInstall);
  assign raddr = idx_q;

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = rdata;
    if (state_q == StDiv && div_done) begin
      we    = 1'b1;
      waddr = item_q.slot;
      wdata.periodic  = item_q.periodic;
      wdata.prio      = item_q.timer_priority;
      wdata.reload    = 32'(div_quo);
      wdata.remaining = 32'(div_quo);
    end else if (state_q == StUpd && valid_q[idx_q]) begin
      we = 1'b1;
      wdata.remaining = exp_hit ? rdata.reload : rdata.remaining - 32'd1;
    end
  end

  always_comb begin
    ovld_d = ovld_q && out_stall_i;
    obuf_d = obuf_q;
    if (emit_exp || emit_fin) begin
      ovld_d = 1'b1;
      obuf_d = '0;
      obuf_d.tick_count     = ticks_q;
      obuf_d.uptime_seconds = secs_q;
      if (emit_exp) begin
        obuf_d.kind         = KindExpire;
        obuf_d.expired_slot = idx_q;
        obuf_d.deliver      = !item_q.task_running ||
                              (item_q.running_priority >= rdata_prio_q);
        obuf_d.last         = last_idx || !more_q;
      end else begin
        obuf_d.kind = (item_q.action == ActTick) ? KindIdle : KindAck;
        obuf_d.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      idx_q   <= '0;
      any_q   <= 1'b0;
      ticks_q <= '0;
      secs_q  <= '0;
      sub_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
      unique case (state_q)
        StIdle: if (acc) begin
          idx_q <= '0;
          any_q <= 1'b0;
          unique case (action_e'(in_data_i.action))
            ActInstall: state_q <= StDiv;
            ActRemove: begin
              if (32'(in_data_i.slot) < NumSlots) valid_q[SlotW'(in_data_i.slot)] <= 1'b0;
              state_q <= StFinal;
            end
            ActTick: begin
              ticks_q <= ticks_q + 32'd1;
              if (sub_q == ($bits(sub_q))'(TickRate - 1) || ticks_q == '1) begin
                sub_q  <= '0;
                secs_q <= secs_q + 32'd1;
              end else begin
                sub_q <= sub_q + 1'b1;
              end
              state_q <= StRead;
            end
            default: state_q <= StFinal;
          endcase
        end
        StDiv: if (div_done) begin
          if (32'(item_q.slot) < NumSlots) valid_q[SlotW'(item_q.slot)] <= 1'b1;
          state_q <= StFinal;
        end
        StRead: state_q <= StUpd;
        StUpd: begin
          if (exp_hit) begin
            any_q <= 1'b1;
            if (!rdata.periodic) valid_q[idx_q] <= 1'b0;
            state_q <= StEmit;
          end else if (last_idx) begin
            state_q <= StFinal;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= StRead;
          end
        end
        StEmit: if (out_free) begin
          if (last_idx) state_q <= StIdle;
          else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= StRead;
          end
        end
        StFinal: if (out_free || fin_silent) begin
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) item_q <= in_data_i;
    obuf_q <= obuf_d;
  end

  always_comb begin
    for (int i = 0; i < NumSlots; i++) hi_mask[i] = (i > int'(idx_q));
  end
  always_ff @(posedge clk_i) begin
    if (state_q == StUpd) begin
      rdata_prio_q <= rdata.prio;
      more_q <= 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        if (hi_mask[i] && valid_q[i] && shadow_le1_q[i]) more_q <= 1'b1;
      end
    end
  end

  // shadow of "remaining <= 1" per slot so the last expiry beat is known early
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) shadow_le1_q <= '0;
    else if (we) shadow_le1_q[waddr] <= (wdata.remaining <= 32'd1);
  end
endmodule

>>> rtl/software_timer_bank_chk.sv
// Port-level checker for the timer bank, bound to the top level.
// Depends on stb_pkg and software_timer_bank_macros.svh.
`include "software_timer_bank_macros.svh"
module software_timer_bank_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input stb_pkg::out_t out_data_o
);
  import stb_pkg::*;
  logic exp_beat;
  logic in_beat;
  assign exp_beat = (out_data_o.kind == KindExpire);
  assign in_beat  = in_valid_i && !in_stall_o;
  `STB_ASSERT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(out_data_o), "held")
  `STB_ASSERT(a_kind, clk_i, rst_ni, out_valid_o |-> out_data_o.kind != KindRsvd, "bad kind")
  `STB_ASSERT(a_nexp, clk_i, rst_ni, out_valid_o && !exp_beat |-> out_data_o.last, "not last")
  `STB_ASSERT(a_busy, clk_i, rst_ni, in_beat |=> in_stall_o, "accepted back to back")
  `STB_ASSERT_ANY(a_rst, clk_i, !rst_ni |=> !out_valid_o, "beat during reset")
endmodule

bind software_timer_bank software_timer_bank_chk u_chk (.*);

>>> verif/testbench.sv
// Testbench for software_timer_bank: directed and random install, remove, no-op and tick
// beats, predicted in-line and compared whole against every output beat.
// Depends on stb_pkg and the software_timer_bank RTL.
`timescale 1ns / 1ps

module testbench;
  import stb_pkg::*;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  logic        bank_valid [NumSlots];
  logic        bank_periodic [NumSlots];
  logic [31:0] bank_reload [NumSlots];
  logic [31:0] bank_remaining [NumSlots];
  logic [7:0]  bank_prio [NumSlots];
  logic [31:0] tick_total = '0;
  logic [31:0] second_total = '0;

  out_t pending_beats[$];
  int   mismatches = 0;

  software_timer_bank DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    out_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data);
      end else begin
        exp_beat = pending_beats.pop_front();
        if (out_data !== exp_beat) begin
          mismatches++;
          if (mismatches <= 10) $display("beat mismatch: expected %p got %p", exp_beat, out_data);
        end
      end
    end
  end

  function automatic out_t make_beat(kind_e kind, logic [3:0] s, logic dl);
    out_t b;
    b = '0;
    b.kind = kind;
    b.expired_slot = s;
    b.deliver = dl;
    b.tick_count = tick_total;
    b.uptime_seconds = second_total;
    return b;
  endfunction

  task automatic predict_timer_bank(in_t item);
    logic [63:0] denom;
    int          n;
    out_t        beats[$];
    n = 0;
    case (action_e'(item.action))
      ActInstall: begin
        denom = (item.resolution == 0) ? 64'd1 : 64'(item.resolution);
        bank_reload[item.slot] = 32'((64'(item.timeout) * TickRate) / denom);
        bank_remaining[item.slot] = bank_reload[item.slot];
        bank_periodic[item.slot] = item.periodic;
        bank_prio[item.slot] = item.timer_priority;
        bank_valid[item.slot] = 1'b1;
        beats.push_back(make_beat(KindAck, '0, 1'b0));
      end
      ActRemove: begin
        bank_valid[item.slot] = 1'b0;
        beats.push_back(make_beat(KindAck, '0, 1'b0));
      end
      ActTick: begin
        tick_total = tick_total + 1;
        if (tick_total % TickRate == 0) second_total = second_total + 1;
        for (int i = 0; i < NumSlots; i++) begin
          if (!bank_valid[i]) continue;
          if (bank_remaining[i] > 1) begin
            bank_remaining[i]--;
            continue;
          end
          if (bank_periodic[i]) bank_remaining[i] = bank_reload[i];
          else bank_valid[i] = 1'b0;
          beats.push_back(make_beat(KindExpire, 4'(i),
                          !item.task_running || item.running_priority >= bank_prio[i]));
        end
        if (beats.size() == 0) beats.push_back(make_beat(KindIdle, '0, 1'b0));
      end
      default: beats.push_back(make_beat(KindAck, '0, 1'b0));
    endcase
    beats[beats.size() - 1].last = 1'b1;
    foreach (beats[k]) pending_beats.push_back(beats[k]);
  endtask

  task automatic send_beat(in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    predict_timer_bank(item);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic in_t make_install(int s, int to, int res, bit per, int pr);
    in_t it;
    it = in_t'($urandom());
    it.action = ActInstall;
    it.slot = 4'(s);
    it.timeout = 16'(to);
    it.resolution = 16'(res);
    it.periodic = per;
    it.timer_priority = 8'(pr);
    return it;
  endfunction

  function automatic in_t make_op(action_e act, int s);
    in_t it;
    it = in_t'({$urandom(), $urandom()});
    it.action = act;
    it.slot = 4'(s);
    return it;
  endfunction

  task automatic test_directed();
    send_beat(make_install(0, 0, 0, 1'b0, 0));
    send_beat(make_install(15, 1, 100, 1'b1, 255));
    send_beat(make_install(3, 65535, 1, 1'b1, 7));
    send_beat(make_install(4, 65535, 65535, 1'b0, 128));
    send_beat(make_install(5, 2, 0, 1'b1, 200));
    send_beat(make_op(ActTick, 0));
    send_beat(make_op(ActTick, 0));
    send_beat(make_install(5, 3, 100, 1'b1, 200));
    send_beat(make_op(ActRemove, 15));
    send_beat(make_op(ActRemove, 9));
    send_beat(make_op(ActNone, 2));
    for (int i = 0; i < 16; i++) send_beat(make_install(i, 0, 5, i[0], i * 16));
    send_beat(make_op(ActTick, 0));
    send_beat(make_op(ActTick, 0));
  endtask

  task automatic test_random(int count);
    in_t it;
    int  pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        if ($urandom_range(3) == 0) it = make_install($urandom_range(15), $urandom(),
                                                      $urandom(), 1'($urandom()), $urandom());
        else it = make_install($urandom_range(15), $urandom_range(8),
                               $urandom_range(100, 0), 1'($urandom()), $urandom());
      end else if (pick < 40) it = make_op(ActRemove, $urandom_range(15));
      else if (pick < 43) it = make_op(ActNone, $urandom_range(15));
      else it = make_op(ActTick, $urandom_range(15));
      send_beat(it);
    end
  endtask

  task automatic drain_beats();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    foreach (bank_valid[i]) bank_valid[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 10;
    recv_idle_pct = 50;
    test_directed();
    test_random(110);
    send_idle_pct = 50;
    recv_idle_pct = 10;
    test_random(110);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(110);
    drain_beats();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
